>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// Needs nothing else; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/atr_pkg.sv
// Constants for the average true range block: field widths, period limits,
// price masking and the divider step count. Depends on nothing.
package atr_pkg;

  localparam int PRICE_W    = 32;   // width of each price and result field
  localparam int PERIOD_W   = 10;   // width of the period register
  localparam int PRICE_BITS = 32;   // price bits taken from each input field
  localparam int SUM_W      = 42;   // seed sum and running average width

  // smoothing dividend avg*(period-1) + tr needs the period bits on top
  localparam int DIV_W      = SUM_W + PERIOD_W;

  localparam logic [PERIOD_W-1:0] PERIOD_MAX   = PERIOD_W'(1023);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(14);

  // Mask that keeps the low PRICE_BITS bits of a price
  localparam logic [PRICE_W-1:0] PRICE_MASK =
    (PRICE_BITS >= PRICE_W) ? {PRICE_W{1'b1}} : PRICE_W'((64'd1 << PRICE_BITS) - 64'd1);

  // One quotient bit per divider step
  localparam int DIV_STEPS = DIV_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

endpackage

>>> rtl/average_true_range.sv
// Wilder average true range: one price bar in, one result word out.
// Uses atr_pkg for widths and limits, assert_macros.svh for the checks.
//
// Each bar word (high, low, close, unsigned Q16.16) produces one result word
// holding the bar's true range, the current average and a ready flag. The
// first 'period' true ranges are summed and divided by the period to seed the
// average; after that the average follows avg = (avg*(period-1) + tr)/period,
// truncated. The average is kept 42 bits wide inside, since a period lowered
// while seeding can push it past 32 bits; the result word shows its low 32
// bits. A bar that divides goes from acceptance to result through a true
// range step in a shared abs-difference/compare unit (TR1 alone on the first
// bar, TR1 to TR3 after it), an accumulate or multiply step, an add step when
// smoothing, a restoring divider by the period, one quotient bit a cycle, and
// the output register. Bars that only add to the seed sum skip the divider.
// The input is not ready while a bar is in work and comes back as the result
// is loaded; the result word sits in an output register until taken, and a
// result still waiting there holds the next one back. Period 0 acts as period 1.
module average_true_range (
  input  logic                          clk,
  input  logic                          rst,
  // period register write
  input  logic                          period_we,
  input  logic [atr_pkg::PERIOD_W-1:0]  period_wdata,
  // bar input: [31:0] bar_high, [63:32] bar_low, [95:64] bar_close
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [3*atr_pkg::PRICE_W-1:0] s_tdata,
  // result: [31:0] avg_range, [63:32] true_range
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [2*atr_pkg::PRICE_W-1:0] m_tdata,
  // result flag: [0] ready_res
  output logic                          m_tuser
);

  localparam int PW = atr_pkg::PRICE_W;
  localparam int QW = atr_pkg::PERIOD_W;
  localparam int SW = atr_pkg::SUM_W;
  localparam int DW = atr_pkg::DIV_W;
  localparam int CW = atr_pkg::DIV_CNT_W;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_TR1  = 3'd1;
  localparam logic [2:0] ST_TR2  = 3'd2;
  localparam logic [2:0] ST_TR3  = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;
  localparam logic [2:0] ST_ADD  = 3'd5;
  localparam logic [2:0] ST_DIV  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0]    state;
  logic [QW-1:0] period;
  logic [PW-1:0] bar_high, bar_low, bar_close;
  logic [PW-1:0] prior_close;
  logic          have_prior;
  logic          seeded;
  logic [QW-1:0] seed_count;
  logic [SW-1:0] seed_sum;
  logic [SW-1:0] avg_value;
  logic [PW-1:0] tr;
  logic [DW-1:0] prod;
  logic [DW-1:0] quo;
  logic [QW-1:0] rem;
  logic [CW-1:0] div_cnt;

  logic [QW-1:0] p_eff;
  logic [PW-1:0] abs_a, abs_b, abs_val;
  logic [PW:0]   diff;
  logic [DW-1:0] add_a, add_out;
  logic [QW-1:0] count_next;
  logic [QW:0]   trial, trial_sub;
  logic          trial_ge;
  logic [DW-1:0] prod_next;
  logic          out_load;

  // effective period: zero acts as one, clamp at the maximum
  always_comb begin
    if (period == '0) begin
      p_eff = QW'(1);
    end else if (period > atr_pkg::PERIOD_MAX) begin
      p_eff = atr_pkg::PERIOD_MAX;
    end else begin
      p_eff = period;
    end
  end

  // shared abs-difference unit, operands picked by state
  always_comb begin
    unique case (state)
      ST_TR2:  begin abs_a = bar_high; abs_b = prior_close; end
      ST_TR3:  begin abs_a = bar_low;  abs_b = prior_close; end
      default: begin abs_a = bar_high; abs_b = bar_low;     end
    endcase
    diff    = {1'b0, abs_a} - {1'b0, abs_b};
    abs_val = diff[PW] ? (~diff[PW-1:0] + PW'(1)) : diff[PW-1:0];
  end

  // shared accumulate adder: seed sum or smoothing product plus true range
  assign add_a   = (state == ST_ACC) ? DW'(seed_sum) : prod;
  assign add_out = add_a + DW'(tr);

  assign count_next = seed_count + QW'(1);

  // smoothing product avg*(p-1)
  assign prod_next = DW'(avg_value) * DW'(p_eff - QW'(1));

  // restoring divider step
  assign trial     = {rem, quo[DW-1]};
  assign trial_sub = trial - {1'b0, p_eff};
  assign trial_ge  = trial >= {1'b0, p_eff};

  assign s_tready = (state == ST_IDLE);

  // result register takes a new word when empty or being drained
  assign out_load = (state == ST_OUT) && (!m_tvalid || m_tready);

  // period register
  always_ff @(posedge clk) begin
    if (rst) begin
      period <= atr_pkg::PERIOD_RESET;
    end else if (period_we) begin
      period <= period_wdata;
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      have_prior  <= 1'b0;
      seeded      <= 1'b0;
      seed_count  <= '0;
      seed_sum    <= '0;
      avg_value   <= '0;
      prior_close <= '0;
      m_tvalid    <= 1'b0;
      div_cnt     <= '0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            bar_high  <= s_tdata[PW-1:0]    & atr_pkg::PRICE_MASK;
            bar_low   <= s_tdata[2*PW-1:PW] & atr_pkg::PRICE_MASK;
            bar_close <= s_tdata[3*PW-1:2*PW] & atr_pkg::PRICE_MASK;
            state     <= ST_TR1;
          end
        end
        ST_TR1: begin
          tr    <= abs_val;
          state <= have_prior ? ST_TR2 : ST_ACC;
        end
        ST_TR2: begin
          if (abs_val > tr) tr <= abs_val;
          state <= ST_TR3;
        end
        ST_TR3: begin
          if (abs_val > tr) tr <= abs_val;
          state <= ST_ACC;
        end
        ST_ACC: begin
          if (!seeded) begin
            seed_count <= count_next;
            seed_sum   <= add_out[SW-1:0];
            if (count_next >= p_eff) begin
              quo     <= add_out;
              rem     <= '0;
              div_cnt <= '0;
              seeded  <= 1'b1;
              state   <= ST_DIV;
            end else begin
              state <= ST_OUT;
            end
          end else begin
            prod  <= prod_next;
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          quo     <= add_out;
          rem     <= '0;
          div_cnt <= '0;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          rem     <= trial_ge ? trial_sub[QW-1:0] : trial[QW-1:0];
          quo     <= {quo[DW-2:0], trial_ge};
          div_cnt <= div_cnt + CW'(1);
          if (div_cnt == CW'(atr_pkg::DIV_STEPS - 1)) begin
            avg_value <= {quo[SW-2:0], trial_ge};
            state     <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            m_tuser     <= seeded;
            m_tdata     <= {tr, seeded ? avg_value[PW-1:0] : PW'(0)};
            prior_close <= bar_close;
            have_prior  <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`include "assert_macros.svh"

  // the average field reads zero until the average is seeded
  `ASSERT_IMPLIES(a_avg_zero_unready, clk, rst, m_tvalid && !m_tuser, m_tdata[PW-1:0] == '0)
  // divider remainder stays below the divisor
  `ASSERT_IMPLIES(a_rem_below_period, clk, rst, state == ST_DIV, rem < p_eff)
  // once seeded, the average stays seeded
  `ASSERT_NEXT(a_seeded_sticks, clk, rst, seeded, seeded)
  // an accepted bar starts at the true range step
  `ASSERT_NEXT(a_accept_starts, clk, rst, s_tvalid && s_tready, state == ST_TR1)

endmodule
